// File: sv/w3f_pkg.sv
// ----------------------------------------------------------------------------
// w3f_pkg
// shared constants, types and helpers of the 3x3 rgb window filter
// ----------------------------------------------------------------------------
`default_nettype none

package w3f_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int CFG_W       = 11;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT + 2);
    localparam int POS_W       = 15;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int WIN_N       = 9;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINE = RECIP_W'((65536 + 8) / 9);
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);
    localparam int IDX_W       = 2;

    typedef enum logic [1:0] {
        MODE_MAX    = 2'd0,
        MODE_MEAN   = 2'd1,
        MODE_MEDIAN = 2'd2
    } mode_t;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic valid;
        logic last;
    } lane_ctl_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } out_item_t;

    function automatic logic [CH_W-1:0] min2(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [CH_W-1:0] max2(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a,
                                             input logic [CH_W-1:0] b,
                                             input logic [CH_W-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

`default_nettype wire

// File: sv/w3f_lane.sv
// ----------------------------------------------------------------------------
// w3f_lane
// one color channel: max, mean of nine and median of a 3x3 window
// ----------------------------------------------------------------------------
`default_nettype none

module w3f_lane import w3f_pkg::*; (
    input  wire logic                       aclk,
    input  wire logic [WIN_N-1:0][CH_W-1:0] vals,
    input  wire logic [1:0]                 mode,
    output logic      [CH_W-1:0]            result
);

    logic [2:0][CH_W-1:0] row_lo_reg, row_md_reg, row_hi_reg;
    logic [2:0][CH_W-1:0] row_lo_next, row_md_next, row_hi_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [CH_W-1:0]      lo_reg, mi_reg, hi_reg, mx_reg, mean_reg;
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [CH_W-1:0]      result_reg, result_next;

    always_comb begin
        sum_next = '0;
        for (int k = 0; k < 3; k++) begin
            row_lo_next[k] = min2(min2(vals[3*k], vals[3*k+1]), vals[3*k+2]);
            row_hi_next[k] = max2(max2(vals[3*k], vals[3*k+1]), vals[3*k+2]);
            row_md_next[k] = med3(vals[3*k], vals[3*k+1], vals[3*k+2]);
        end
        for (int i = 0; i < WIN_N; i++) begin
            sum_next = sum_next + SUM_W'(vals[i]);
        end
    end

    assign prod = SUM_W'(sum_reg) * RECIP_NINE;

    always_comb begin
        case (mode)
            MODE_MAX:  result_next = mx_reg;
            MODE_MEAN: result_next = mean_reg;
            default:   result_next = med3(lo_reg, mi_reg, hi_reg);
        endcase
    end

    always_ff @(posedge aclk) begin
        row_lo_reg <= row_lo_next;
        row_md_reg <= row_md_next;
        row_hi_reg <= row_hi_next;
        sum_reg    <= sum_next;
        lo_reg     <= max2(max2(row_lo_reg[0], row_lo_reg[1]), row_lo_reg[2]);
        mi_reg     <= med3(row_md_reg[0], row_md_reg[1], row_md_reg[2]);
        hi_reg     <= min2(min2(row_hi_reg[0], row_hi_reg[1]), row_hi_reg[2]);
        mx_reg     <= max2(max2(row_hi_reg[0], row_hi_reg[1]), row_hi_reg[2]);
        mean_reg   <= prod[RECIP_SHIFT +: CH_W];
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// File: sv/w3f_window.sv
// ----------------------------------------------------------------------------
// w3f_window
// stream position, two-row line memory and the 3x3 window with edge masking
// ----------------------------------------------------------------------------
`default_nettype none

module w3f_window import w3f_pkg::*; (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        accept,
    input  wire logic                        command,
    input  wire logic [PIX_W-1:0]            pixel,
    input  wire logic [CFG_W-1:0]            width_eff,
    input  wire logic [CFG_W-1:0]            height_eff,
    output logic      [WIN_N-1:0][PIX_W-1:0] win_pix,
    output lane_ctl_t                        win_ctl,
    output logic                             drop
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    logic signed [POS_W-1:0] c_x, r_x, w_x, h_x, c0, r0, cr, cc;
    logic                    wrap, has_res, top, bot, left, right, last;
    logic [PIX_W-1:0]        pix0;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_reg;

    logic               s1_v_reg, s1_res_reg, s1_last_reg;
    logic               s1_top_reg, s1_bot_reg, s1_left_reg, s1_right_reg;
    logic [COL_W-1:0]   s1_addr_reg;
    logic [PIX_W-1:0]   s1_pix_reg;

    logic               wp_v_reg;
    logic [COL_W-1:0]   wp_addr_reg;
    logic [2*PIX_W-1:0] wp_data_reg;
    logic [2*PIX_W-1:0] rd_eff, wr_data;

    logic [WIN_N-1:0][PIX_W-1:0] win_reg, win_next, mask_next, s2_pix_reg;
    lane_ctl_t                   s2_ctl_reg;

    always_comb begin
        c_x  = POS_W'(col_reg);
        r_x  = POS_W'(row_reg);
        w_x  = POS_W'(width_eff);
        h_x  = POS_W'(height_eff);
        wrap = (c_x >= w_x) || (r_x > h_x + 1);
        c0   = wrap ? '0 : c_x;
        r0   = wrap ? '0 : r_x;
        pix0 = (command == CMD_PIXEL && r0 < h_x) ? pixel : '0;
        if (c0 != 0) begin
            cr = r0 - 1;
            cc = c0 - 1;
        end else begin
            cr = r0 - 2;
            cc = w_x - 1;
        end
        has_res = (cr >= 0) && (cr < h_x);
        top     = (cr == 0);
        bot     = (cr == h_x - 1);
        left    = (cc == 0);
        right   = (cc == w_x - 1);
        last    = has_res && bot && right;
        if (last || r0 >= h_x + 1) begin
            col_next = '0;
            row_next = '0;
        end else if (c0 + 1 >= w_x) begin
            col_next = '0;
            row_next = ROW_W'(r0 + 1);
        end else begin
            col_next = COL_W'(c0 + 1);
            row_next = ROW_W'(r0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            s1_v_reg <= 1'b0;
            wp_v_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_v_reg <= accept;
            wp_v_reg <= s1_v_reg;
        end
    end

    // line memory: upper row in the high half, middle row in the low half
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_reg <= mem[COL_W'(c0)];
        end
        if (s1_v_reg) begin
            mem[s1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg  <= COL_W'(c0);
            s1_pix_reg   <= pix0;
            s1_res_reg   <= has_res;
            s1_last_reg  <= last;
            s1_top_reg   <= top;
            s1_bot_reg   <= bot;
            s1_left_reg  <= left;
            s1_right_reg <= right;
        end
        wp_addr_reg <= s1_addr_reg;
        wp_data_reg <= wr_data;
    end

    // write of the previous item has not landed yet when it hits the same column
    assign rd_eff  = (wp_v_reg && wp_addr_reg == s1_addr_reg) ? wp_data_reg : rd_reg;
    assign wr_data = {rd_eff[PIX_W-1:0], s1_pix_reg};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            win_next[3*k]   = win_reg[3*k+1];
            win_next[3*k+1] = win_reg[3*k+2];
        end
        win_next[2] = rd_eff[2*PIX_W-1:PIX_W];
        win_next[5] = rd_eff[PIX_W-1:0];
        win_next[8] = s1_pix_reg;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ((i == 0 && s1_top_reg) || (i == 2 && s1_bot_reg) ||
                    (j == 0 && s1_left_reg) || (j == 2 && s1_right_reg)) begin
                    mask_next[3*i+j] = '0;
                end else begin
                    mask_next[3*i+j] = win_next[3*i+j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg    <= '0;
            s2_ctl_reg <= '0;
        end else begin
            if (s1_v_reg) begin
                win_reg <= win_next;
            end
            s2_ctl_reg.valid <= s1_v_reg && s1_res_reg;
            s2_ctl_reg.last  <= s1_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_pix_reg <= mask_next;
    end

    assign win_pix = s2_pix_reg;
    assign win_ctl = s2_ctl_reg;
    assign drop    = s1_v_reg && !s1_res_reg;

endmodule

`default_nettype wire

// File: sv/w3f_out_fifo.sv
// ----------------------------------------------------------------------------
// w3f_out_fifo
// buffers merged output items and tracks credit for the input side
// ----------------------------------------------------------------------------
`default_nettype none

module w3f_out_fifo import w3f_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      accept,
    input  wire logic      drop,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);

    out_item_t          buf_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic [FIFO_CW-1:0] pending_reg, pending_next;
    logic               pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != '0);
    assign m_item  = buf_reg[rd_ptr_reg];
    assign s_ready = (pending_reg < FIFO_CW'(FIFO_DEPTH));

    always_comb begin
        count_next   = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
        pending_next = pending_reg + FIFO_CW'(accept) - FIFO_CW'(drop) - FIFO_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            pending_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg   <= count_next;
            pending_reg <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && !pop && count_reg == FIFO_CW'(FIFO_DEPTH)))
        else $error("result buffer overflow");

    a_credit_covers: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= pending_reg)
        else $error("buffered items exceed outstanding credit");

    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("count did not drop on pop");

endmodule

`default_nettype wire

// File: sv/window_3x3_rgb_filter_unit.sv
// ----------------------------------------------------------------------------
// window_3x3_rgb_filter_unit
// 3x3 max / mean / median filter on rgb pixel streams, one lane per channel
// ----------------------------------------------------------------------------
// throughput: one item per cycle while s_ready is high; the line memory read and the
//   window update overlap the next item, and results wait in an 8-entry output buffer
// result: the result for pixel k comes with item k + width + 1, then passes the lane registers and the output buffer
// reset: synchronous active-low aresetn clears position, window and buffer;
//   registers return to median, 1024 x 1024; line memory has no reset
`default_nettype none

module window_3x3_rgb_filter_unit import w3f_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_command,
    input  wire logic [CH_W-1:0]  s_pixel_red,
    input  wire logic [CH_W-1:0]  s_pixel_green,
    input  wire logic [CH_W-1:0]  s_pixel_blue,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [CH_W-1:0]  m_out_red,
    output logic      [CH_W-1:0]  m_out_green,
    output logic      [CH_W-1:0]  m_out_blue,
    output logic                  m_frame_end
);

    logic [1:0]       mode_reg;
    logic [CFG_W-1:0] width_reg, height_reg, width_eff, height_eff;

    logic                        accept, drop;
    logic [WIN_N-1:0][PIX_W-1:0] win_pix;
    lane_ctl_t                   win_ctl, ctl_a_reg, ctl_b_reg, ctl_c_reg;
    logic [2:0][CH_W-1:0]        lane_res;
    out_item_t                   push_item, m_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_MEDIAN;
            width_reg  <= CFG_W'(MAX_WIDTH);
            height_reg <= CFG_W'(MAX_HEIGHT);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:   mode_reg   <= cfg_data[1:0];
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    assign width_eff  = (width_reg == '0) ? CFG_W'(1) :
                        (width_reg > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_reg;
    assign height_eff = (height_reg == '0) ? CFG_W'(1) :
                        (height_reg > CFG_W'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : height_reg;

    assign accept = s_valid && s_ready;

    w3f_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .command    (s_command),
        .pixel      ({s_pixel_red, s_pixel_green, s_pixel_blue}),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .win_pix    (win_pix),
        .win_ctl    (win_ctl),
        .drop       (drop)
    );

    // lane 0 red, lane 1 green, lane 2 blue
    for (genvar s = 0; s < 3; s++) begin : g_lane
        logic [WIN_N-1:0][CH_W-1:0] vals;
        always_comb begin
            for (int i = 0; i < WIN_N; i++) begin
                vals[i] = win_pix[i][PIX_W-1-CH_W*s -: CH_W];
            end
        end
        w3f_lane u_lane (
            .aclk   (aclk),
            .vals   (vals),
            .mode   (mode_reg),
            .result (lane_res[s])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end else begin
            ctl_a_reg <= win_ctl;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    assign push_item.red   = lane_res[0];
    assign push_item.green = lane_res[1];
    assign push_item.blue  = lane_res[2];
    assign push_item.last  = ctl_c_reg.last;

    w3f_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .drop      (drop),
        .push      (ctl_c_reg.valid),
        .push_item (push_item),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    assign m_out_red   = m_item.red;
    assign m_out_green = m_item.green;
    assign m_out_blue  = m_item.blue;
    assign m_frame_end = m_item.last;

endmodule

`default_nettype wire
